// ----- sv/isbn10_line_checker_defines.svh -----
// Assertion macros for the checker file of the ISBN-10 line checker.
`ifndef ISBN10_LINE_CHECKER_DEFINES_SVH
`define ISBN10_LINE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISBN10LC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isbn10lc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISBN10LC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isbn10lc: next-cycle check failed");

`endif

// ----- sv/isbn10lc_pkg.sv -----
// Package of character codes, limits and the modulo-11 adder for the ISBN-10 line checker.
package isbn10lc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN  = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_X_UPPER = 8'd88;
  localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 8'd120;

  localparam logic [DIGIT_W:0]   MODULUS    = 5'd11;
  localparam logic [DIGIT_W-1:0] COUNT_SAT  = 4'd11;
  localparam logic [DIGIT_W-1:0] ISBN_LEN   = 4'd10;
  localparam logic [DIGIT_W-1:0] TENTH_POS  = 4'd9;
  localparam logic [DIGIT_W-1:0] X_VALUE    = 4'd10;

  typedef logic [DIGIT_W-1:0] mod11_t;

  // Sum of two residues below 11, reduced once more to a residue below 11.
  function automatic mod11_t add_mod11(input mod11_t a, input mod11_t b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= MODULUS) ? DIGIT_W'(s - MODULUS) : s[DIGIT_W-1:0];
  endfunction

endpackage

// ----- sv/isbn10_line_checker.sv -----
// Top level of the ISBN-10 line checker: input register, per-line state and result register.
//
// The block reads one line of text, one character item per cycle while in_stall
// is low, closed by a terminator item (in_end_of_line high), and gives one
// result item per line: out_is_correct is 1 when the line is a valid ISBN-10.
// Leading and trailing spaces are ignored, hyphens are skipped, digits count 0
// to 9 and an X or x counts 10 only as the tenth symbol. Anything else,
// including a space with content on both sides, makes the line incorrect; an
// empty line is incorrect. An accepted item sits in the input register while
// the character classifier and two chained modulo-11 adders update the line
// state, and a terminator then loads the result register. A new item is
// accepted every cycle unless in_stall is high. in_stall rises only when a
// terminator waits in the input register while the result register still
// holds an untaken result.
module isbn10_line_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [isbn10lc_pkg::CHAR_W-1:0] in_char_code,
  input  logic                           in_end_of_line,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_correct
);
  import isbn10lc_pkg::*;

  // Input register.
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_eol_r;

  // Line state.
  mod11_t sum_digits_r, sum_digits_nxt;
  mod11_t sum_of_sums_r, sum_of_sums_nxt;
  mod11_t symbol_count_r, symbol_count_nxt;
  logic   bad_line_r, bad_line_nxt;
  logic   seen_content_r, seen_content_nxt;
  logic   space_pending_r, space_pending_nxt;

  // Result register.
  logic out_valid_r;
  logic out_is_correct_r;

  logic   advance;
  logic   in_accept;
  logic   line_ok;
  logic   is_space, is_digit, is_x, is_hyphen;
  logic   take;
  mod11_t take_value;
  mod11_t sd_add;

  // An ordinary character always leaves the input register; a terminator
  // needs a free (or emptying) result register.
  assign advance   = s1_valid_r && (!s1_eol_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign is_space  = (s1_char_r == CHAR_SPACE);
  assign is_hyphen = (s1_char_r == CHAR_HYPHEN);
  assign is_digit  = (s1_char_r >= CHAR_ZERO) && (s1_char_r <= CHAR_NINE);
  assign is_x      = (s1_char_r == CHAR_X_UPPER) || (s1_char_r == CHAR_X_LOWER);

  assign line_ok = !bad_line_r && (symbol_count_r == ISBN_LEN) && (sum_of_sums_r == '0);

  // A symbol is taken only while the line is still good and no inner space
  // was found before this character.
  always_comb begin
    take       = 1'b0;
    take_value = is_digit ? DIGIT_W'(s1_char_r - CHAR_ZERO) : X_VALUE;
    if (!bad_line_r && !space_pending_r) begin
      if (is_digit) begin
        take = 1'b1;
      end else if (is_x && (symbol_count_r == TENTH_POS)) begin
        take = 1'b1;
      end
    end
  end

  assign sd_add = add_mod11(sum_digits_r, take_value);

  always_comb begin
    sum_digits_nxt    = sum_digits_r;
    sum_of_sums_nxt   = sum_of_sums_r;
    symbol_count_nxt  = symbol_count_r;
    bad_line_nxt      = bad_line_r;
    seen_content_nxt  = seen_content_r;
    space_pending_nxt = space_pending_r;
    if (advance) begin
      if (s1_eol_r) begin
        // The line is finished: everything clears for the next one.
        sum_digits_nxt    = '0;
        sum_of_sums_nxt   = '0;
        symbol_count_nxt  = '0;
        bad_line_nxt      = 1'b0;
        seen_content_nxt  = 1'b0;
        space_pending_nxt = 1'b0;
      end else if (is_space) begin
        // Leading spaces are dropped; later ones wait to see if content follows.
        if (seen_content_r) begin
          space_pending_nxt = 1'b1;
        end
      end else begin
        seen_content_nxt  = 1'b1;
        space_pending_nxt = 1'b0;
        if (bad_line_r || space_pending_r) begin
          bad_line_nxt = 1'b1;
        end else if (take) begin
          sum_digits_nxt  = sd_add;
          sum_of_sums_nxt = add_mod11(sum_of_sums_r, sd_add);
          if (symbol_count_r < COUNT_SAT) begin
            symbol_count_nxt = symbol_count_r + 1'b1;
          end
        end else if (!is_hyphen) begin
          // Any other byte, or an X that is not the tenth symbol.
          bad_line_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      sum_digits_r    <= '0;
      sum_of_sums_r   <= '0;
      symbol_count_r  <= '0;
      bad_line_r      <= 1'b0;
      seen_content_r  <= 1'b0;
      space_pending_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance && s1_eol_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      sum_digits_r    <= sum_digits_nxt;
      sum_of_sums_r   <= sum_of_sums_nxt;
      symbol_count_r  <= symbol_count_nxt;
      bad_line_r      <= bad_line_nxt;
      seen_content_r  <= seen_content_nxt;
      space_pending_r <= space_pending_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_char_code;
      s1_eol_r  <= in_end_of_line;
    end
    if (advance && s1_eol_r) begin
      out_is_correct_r <= line_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_correct = out_is_correct_r;

endmodule

// ----- sv/isbn10lc_checker.sv -----
// Port-level assertions for the ISBN-10 line checker and the bind that attaches them.
`include "isbn10_line_checker_defines.svh"

module isbn10lc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [isbn10lc_pkg::CHAR_W-1:0] in_char_code,
  input logic                            in_end_of_line,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_is_correct
);

  // A stalled result stays offered and unchanged.
  `ISBN10LC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_is_correct))

  // A stalled input item stays offered and unchanged.
  `ISBN10LC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                        in_valid && $stable({in_char_code, in_end_of_line}))

  // The input side is held back only by a result that waits downstream.
  `ISBN10LC_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // No result is offered in the first cycle after reset.
  `ISBN10LC_ASSERT_SAME(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid && !in_stall)

endmodule

bind isbn10_line_checker isbn10lc_checker u_isbn10lc_checker (.*);
